FILE: hw/rtl/sdmrc_pkg.sv
// shared constants and types for the stick deadzone map and radial clamp
// used by sdmrc_axis, sdmrc_radial and the top level
package sdmrc_pkg;

    localparam int RAW_W   = 12;
    localparam int OUTER_W = 11;
    localparam int OUT_W   = 15;

    localparam logic [13:0] MID     = 14'd16383;
    localparam logic [14:0] GAIN_HI = 15'd16384;
    localparam logic [56:0] MID_SQ  = 57'd268402689;

    // axis map widths
    localparam int AX_NUM_W = 14;
    localparam int AX_Q_W   = 28;
    localparam int AX_MAG_W = 28;

    // radial clamp widths
    localparam int SQ_W     = 57;
    localparam int ROOT_W   = 45;
    localparam int SREM_W   = 48;
    localparam int PROD_W   = 42;
    localparam int DREM_W   = 58;
    localparam int SC_Q_W   = 15;

    localparam int LATENCY = 96;

    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_LOW_X    = 3'd2;
    localparam logic [2:0] REG_HIGH_X   = 3'd3;
    localparam logic [2:0] REG_LOW_Y    = 3'd4;
    localparam logic [2:0] REG_HIGH_Y   = 3'd5;
    localparam logic [2:0] REG_INNER    = 3'd6;
    localparam logic [2:0] REG_OUTER    = 3'd7;

    typedef struct packed {
        logic [RAW_W-1:0]   center;
        logic [RAW_W-1:0]   low;
        logic [RAW_W-1:0]   high;
        logic [RAW_W-1:0]   inner;
        logic [OUTER_W-1:0] outer;
    } axis_cfg_t;

    typedef struct packed {
        logic                valid;
        logic                neg;
        logic [AX_MAG_W-1:0] mag;
    } axis_res_t;

endpackage

FILE: hw/rtl/sdmrc_axis.sv
// one axis: inner deadzone, outer trim clamp and split-range linear map
// gives the offset from mid-scale as sign and magnitude; uses sdmrc_pkg
module sdmrc_axis (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [sdmrc_pkg::RAW_W-1:0] raw,
    input  sdmrc_pkg::axis_cfg_t      cfg,
    output sdmrc_pkg::axis_res_t      res
);
    import sdmrc_pkg::*;

    // stage 1: trim limits and deadzone test
    logic               v1_reg;
    logic [RAW_W-1:0]   raw1_reg;
    logic signed [13:0] lo1_reg;
    logic signed [13:0] hi1_reg;
    logic               dz1_reg;

    logic signed [12:0] diff;
    logic [12:0]        adiff;
    logic signed [13:0] lo_next;
    logic signed [13:0] hi_next;

    always_comb
    begin
        diff    = $signed({1'b0, raw}) - $signed({1'b0, cfg.center});
        adiff   = diff[12] ? 13'(-diff) : 13'(diff);
        lo_next = $signed({2'b0, cfg.low}) + $signed({3'b0, cfg.outer});
        hi_next = $signed({2'b0, cfg.high}) - $signed({3'b0, cfg.outer});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        raw1_reg <= raw;
        lo1_reg  <= lo_next;
        hi1_reg  <= hi_next;
        dz1_reg  <= adiff < {1'b0, cfg.inner};
    end

    // stage 2: clamp, pick branch, numerator and span
    logic               v2_reg;
    logic               snap2_reg;
    logic               upper2_reg;
    logic               nneg2_reg;
    logic               dneg2_reg;
    logic [13:0]        nmag2_reg;
    logic [13:0]        dmag2_reg;

    logic signed [13:0] v14;
    logic signed [13:0] c14;
    logic signed [13:0] vc;
    logic               le;
    logic signed [14:0] num;
    logic signed [14:0] den;

    always_comb
    begin
        v14 = $signed({2'b0, raw1_reg});
        c14 = $signed({2'b0, cfg.center});
        priority if (v14 < lo1_reg)
            vc = lo1_reg;
        else if (v14 > hi1_reg)
            vc = hi1_reg;
        else
            vc = v14;
        le = vc <= c14;
        if (le)
        begin
            num = 15'(vc) - 15'(lo1_reg);
            den = 15'(c14) - 15'(lo1_reg);
        end
        else
        begin
            num = 15'(vc) - 15'(c14);
            den = 15'(hi1_reg) - 15'(c14);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        snap2_reg  <= dz1_reg || (den == 15'sd0);
        upper2_reg <= !le;
        nneg2_reg  <= num[14];
        dneg2_reg  <= den[14];
        nmag2_reg  <= num[14] ? 14'(-num) : 14'(num);
        dmag2_reg  <= den[14] ? 14'(-den) : 14'(den);
    end

    // stage 3 is divider entry 0: scaled numerator
    logic               dv_reg    [0:AX_Q_W];
    logic [AX_Q_W-1:0]  drem_reg  [0:AX_Q_W];
    logic [AX_Q_W-1:0]  dq_reg    [0:AX_Q_W];
    logic [13:0]        dden_reg  [0:AX_Q_W];
    logic               dneg_reg  [0:AX_Q_W];
    logic               dsnap_reg [0:AX_Q_W];
    logic               dup_reg   [0:AX_Q_W];

    logic [28:0] prod;

    assign prod = 29'(nmag2_reg) * 29'(upper2_reg ? GAIN_HI : {1'b0, MID});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        drem_reg[0]  <= prod[AX_Q_W-1:0];
        dq_reg[0]    <= '0;
        dden_reg[0]  <= dmag2_reg;
        dneg_reg[0]  <= nneg2_reg ^ dneg2_reg;
        dsnap_reg[0] <= snap2_reg;
        dup_reg[0]   <= upper2_reg;
    end

    // restoring divider, one quotient bit per stage, msb first
    genvar j;
    generate
        for (j = 1; j <= AX_Q_W; j++)
        begin : g_div
            logic [AX_Q_W+13:0] dvs;
            logic               ge;

            always_comb
            begin
                dvs = {{AX_Q_W{1'b0}}, dden_reg[j-1]} << (AX_Q_W - j);
                ge  = {14'b0, drem_reg[j-1]} >= dvs;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_reg[j] <= 1'b0;
                end
                else
                begin
                    dv_reg[j] <= dv_reg[j-1];
                end
            end

            always_ff @(posedge clk)
            begin
                drem_reg[j]  <= ge ? drem_reg[j-1] - dvs[AX_Q_W-1:0] : drem_reg[j-1];
                dq_reg[j]    <= {dq_reg[j-1][AX_Q_W-2:0], ge};
                dden_reg[j]  <= dden_reg[j-1];
                dneg_reg[j]  <= dneg_reg[j-1];
                dsnap_reg[j] <= dsnap_reg[j-1];
                dup_reg[j]   <= dup_reg[j-1];
            end
        end
    endgenerate

    // output stage: signed offset from mid-scale
    logic                valid_reg;
    logic                neg_reg;
    logic [AX_MAG_W-1:0] mag_reg;

    logic signed [29:0] sq;
    logic signed [29:0] d;

    always_comb
    begin
        sq = $signed({2'b0, dq_reg[AX_Q_W]});
        if (dneg_reg[AX_Q_W])
            sq = -sq;
        if (!dup_reg[AX_Q_W])
            sq = sq - $signed({16'b0, MID});
        d = dsnap_reg[AX_Q_W] ? 30'sd0 : sq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= dv_reg[AX_Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= d[29];
        mag_reg <= d[29] ? AX_MAG_W'(-d) : AX_MAG_W'(d);
    end

    assign res.valid = valid_reg;
    assign res.neg   = neg_reg;
    assign res.mag   = mag_reg;

endmodule

FILE: hw/rtl/sdmrc_radial.sv
// radial clamp: squared radius, pipelined square root and scaling dividers
// pulls points outside the circle of radius mid onto it; uses sdmrc_pkg
module sdmrc_radial (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sdmrc_pkg::axis_res_t        ax,
    input  sdmrc_pkg::axis_res_t        ay,
    output logic                        out_valid,
    output logic [sdmrc_pkg::OUT_W-1:0] out_x,
    output logic [sdmrc_pkg::OUT_W-1:0] out_y
);
    import sdmrc_pkg::*;

    // stage 1: squares
    logic                v1_reg;
    logic [55:0]         sqx1_reg;
    logic [55:0]         sqy1_reg;
    logic [AX_MAG_W-1:0] mx1_reg;
    logic [AX_MAG_W-1:0] my1_reg;
    logic                nx1_reg;
    logic                ny1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ax.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sqx1_reg <= 56'(ax.mag) * 56'(ax.mag);
        sqy1_reg <= 56'(ay.mag) * 56'(ay.mag);
        mx1_reg  <= ax.mag;
        my1_reg  <= ay.mag;
        nx1_reg  <= ax.neg;
        ny1_reg  <= ay.neg;
    end

    // stage 2 is root entry 0: sum and outside test
    logic                rv_reg   [0:ROOT_W];
    logic [SQ_W-1:0]     rs_reg   [0:ROOT_W];
    logic [SREM_W-1:0]   rrem_reg [0:ROOT_W];
    logic [ROOT_W-1:0]   rt_reg   [0:ROOT_W];
    logic [AX_MAG_W-1:0] rmx_reg  [0:ROOT_W];
    logic [AX_MAG_W-1:0] rmy_reg  [0:ROOT_W];
    logic                rnx_reg  [0:ROOT_W];
    logic                rny_reg  [0:ROOT_W];
    logic                rout_reg [0:ROOT_W];

    logic [SQ_W-1:0] ssum;

    assign ssum = SQ_W'(sqx1_reg) + SQ_W'(sqy1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg[0] <= 1'b0;
        end
        else
        begin
            rv_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rs_reg[0]   <= ssum;
        rrem_reg[0] <= '0;
        rt_reg[0]   <= '0;
        rmx_reg[0]  <= mx1_reg;
        rmy_reg[0]  <= my1_reg;
        rnx_reg[0]  <= nx1_reg;
        rny_reg[0]  <= ny1_reg;
        rout_reg[0] <= ssum > MID_SQ;
    end

    // square root of s * 2^32, one bit pair per stage
    genvar j;
    generate
        for (j = 1; j <= ROOT_W; j++)
        begin : g_root
            logic [89:0]       rad;
            logic [1:0]        pair;
            logic [SREM_W-1:0] remsh;
            logic [SREM_W-1:0] trial;
            logic              ge;

            always_comb
            begin
                rad   = {1'b0, rs_reg[j-1], 32'b0};
                pair  = rad[91-2*j -: 2];
                remsh = {rrem_reg[j-1][SREM_W-3:0], pair};
                trial = {1'b0, rt_reg[j-1], 2'b01};
                ge    = remsh >= trial;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    rv_reg[j] <= 1'b0;
                end
                else
                begin
                    rv_reg[j] <= rv_reg[j-1];
                end
            end

            always_ff @(posedge clk)
            begin
                rs_reg[j]   <= rs_reg[j-1];
                rrem_reg[j] <= ge ? remsh - trial : remsh;
                rt_reg[j]   <= {rt_reg[j-1][ROOT_W-2:0], ge};
                rmx_reg[j]  <= rmx_reg[j-1];
                rmy_reg[j]  <= rmy_reg[j-1];
                rnx_reg[j]  <= rnx_reg[j-1];
                rny_reg[j]  <= rny_reg[j-1];
                rout_reg[j] <= rout_reg[j-1];
            end
        end
    endgenerate

    // scaling divider entry 0: component times mid
    logic                sv_reg   [0:SC_Q_W];
    logic [DREM_W-1:0]   sremx_reg[0:SC_Q_W];
    logic [DREM_W-1:0]   sremy_reg[0:SC_Q_W];
    logic [SC_Q_W-1:0]   sqx_reg  [0:SC_Q_W];
    logic [SC_Q_W-1:0]   sqy_reg  [0:SC_Q_W];
    logic [ROOT_W-1:0]   sm_reg   [0:SC_Q_W];
    logic [AX_MAG_W-1:0] smx_reg  [0:SC_Q_W];
    logic [AX_MAG_W-1:0] smy_reg  [0:SC_Q_W];
    logic                snx_reg  [0:SC_Q_W];
    logic                sny_reg  [0:SC_Q_W];
    logic                sout_reg [0:SC_Q_W];

    logic [PROD_W-1:0] px;
    logic [PROD_W-1:0] py;

    assign px = PROD_W'(rmx_reg[ROOT_W]) * PROD_W'(MID);
    assign py = PROD_W'(rmy_reg[ROOT_W]) * PROD_W'(MID);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg[0] <= 1'b0;
        end
        else
        begin
            sv_reg[0] <= rv_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        sremx_reg[0] <= {px, 16'b0};
        sremy_reg[0] <= {py, 16'b0};
        sqx_reg[0]   <= '0;
        sqy_reg[0]   <= '0;
        sm_reg[0]    <= rt_reg[ROOT_W];
        smx_reg[0]   <= rmx_reg[ROOT_W];
        smy_reg[0]   <= rmy_reg[ROOT_W];
        snx_reg[0]   <= rnx_reg[ROOT_W];
        sny_reg[0]   <= rny_reg[ROOT_W];
        sout_reg[0]  <= rout_reg[ROOT_W];
    end

    // quotient never exceeds mid, so fifteen bits cover it
    generate
        for (j = 1; j <= SC_Q_W; j++)
        begin : g_scale
            logic [DREM_W+1:0] dvs;
            logic              gex;
            logic              gey;

            always_comb
            begin
                dvs = {{(DREM_W+2-ROOT_W){1'b0}}, sm_reg[j-1]} << (SC_Q_W - j);
                gex = {2'b0, sremx_reg[j-1]} >= dvs;
                gey = {2'b0, sremy_reg[j-1]} >= dvs;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sv_reg[j] <= 1'b0;
                end
                else
                begin
                    sv_reg[j] <= sv_reg[j-1];
                end
            end

            always_ff @(posedge clk)
            begin
                sremx_reg[j] <= gex ? sremx_reg[j-1] - dvs[DREM_W-1:0] : sremx_reg[j-1];
                sremy_reg[j] <= gey ? sremy_reg[j-1] - dvs[DREM_W-1:0] : sremy_reg[j-1];
                sqx_reg[j]   <= {sqx_reg[j-1][SC_Q_W-2:0], gex};
                sqy_reg[j]   <= {sqy_reg[j-1][SC_Q_W-2:0], gey};
                sm_reg[j]    <= sm_reg[j-1];
                smx_reg[j]   <= smx_reg[j-1];
                smy_reg[j]   <= smy_reg[j-1];
                snx_reg[j]   <= snx_reg[j-1];
                sny_reg[j]   <= sny_reg[j-1];
                sout_reg[j]  <= sout_reg[j-1];
            end
        end
    endgenerate

    // output stage: add mid back
    logic                valid_reg;
    logic [OUT_W-1:0]    x_reg;
    logic [OUT_W-1:0]    y_reg;

    logic [AX_MAG_W-1:0] ax_mag;
    logic [AX_MAG_W-1:0] ay_mag;
    logic [AX_MAG_W-1:0] xs;
    logic [AX_MAG_W-1:0] ys;

    always_comb
    begin
        ax_mag = sout_reg[SC_Q_W] ? AX_MAG_W'(sqx_reg[SC_Q_W]) : smx_reg[SC_Q_W];
        ay_mag = sout_reg[SC_Q_W] ? AX_MAG_W'(sqy_reg[SC_Q_W]) : smy_reg[SC_Q_W];
        xs = snx_reg[SC_Q_W] ? AX_MAG_W'(MID) - ax_mag : AX_MAG_W'(MID) + ax_mag;
        ys = sny_reg[SC_Q_W] ? AX_MAG_W'(MID) - ay_mag : AX_MAG_W'(MID) + ay_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= sv_reg[SC_Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= xs[OUT_W-1:0];
        y_reg <= ys[OUT_W-1:0];
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

endmodule

FILE: hw/rtl/stick_deadzone_map_radial_clamp.sv
// analogue stick conditioning top level: config registers, two axis maps, radial clamp
// depends on sdmrc_pkg, sdmrc_axis and sdmrc_radial
//
// usage:
//   input: raw_x, raw_y are taken at a rising edge with start high and busy low.
//   busy stays low, so a new sample pair may be given in every cycle.
//   output: done is high for one cycle with out_x, out_y; that cycle's closing
//   edge is the transfer. the receiver cannot hold results off, and none is
//   needed: the pipeline never stalls.
//   throughput is one pair per cycle. the depth is set by the 28-stage
//   axis divider, the 45-stage square root and the 15-stage scaling
//   divider, each doing one bit (or bit pair) per stage.
//   config: cfg_we with cfg_index and cfg_data writes one register at the
//   edge; write only while no sample is in flight.
//   reset: rst_n low clears all valid bits and loads the calibration
//   defaults (centers 2047, full 0..4095 range, inner deadzone 150,
//   no outer trim).
module stick_deadzone_map_radial_clamp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [sdmrc_pkg::RAW_W-1:0] raw_x,
    input  logic [sdmrc_pkg::RAW_W-1:0] raw_y,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [sdmrc_pkg::RAW_W-1:0] cfg_data,
    output logic                        done,
    output logic [sdmrc_pkg::OUT_W-1:0] out_x,
    output logic [sdmrc_pkg::OUT_W-1:0] out_y
);
    import sdmrc_pkg::*;

    logic [RAW_W-1:0]   center_x_reg;
    logic [RAW_W-1:0]   center_y_reg;
    logic [RAW_W-1:0]   low_x_reg;
    logic [RAW_W-1:0]   high_x_reg;
    logic [RAW_W-1:0]   low_y_reg;
    logic [RAW_W-1:0]   high_y_reg;
    logic [RAW_W-1:0]   inner_reg;
    logic [OUTER_W-1:0] outer_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= 12'd2047;
            center_y_reg <= 12'd2047;
            low_x_reg    <= 12'd0;
            high_x_reg   <= 12'd4095;
            low_y_reg    <= 12'd0;
            high_y_reg   <= 12'd4095;
            inner_reg    <= 12'd150;
            outer_reg    <= 11'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_LOW_X:    low_x_reg    <= cfg_data;
                REG_HIGH_X:   high_x_reg   <= cfg_data;
                REG_LOW_Y:    low_y_reg    <= cfg_data;
                REG_HIGH_Y:   high_y_reg   <= cfg_data;
                REG_INNER:    inner_reg    <= cfg_data;
                REG_OUTER:    outer_reg    <= cfg_data[OUTER_W-1:0];
                default:      outer_reg    <= outer_reg;
            endcase
        end
    end

    axis_cfg_t cfg_x;
    axis_cfg_t cfg_y;
    axis_res_t res_x;
    axis_res_t res_y;
    logic      accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign cfg_x = '{center: center_x_reg, low: low_x_reg, high: high_x_reg,
                     inner: inner_reg, outer: outer_reg};
    assign cfg_y = '{center: center_y_reg, low: low_y_reg, high: high_y_reg,
                     inner: inner_reg, outer: outer_reg};

    sdmrc_axis u_axis_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .raw      (raw_x),
        .cfg      (cfg_x),
        .res      (res_x)
    );

    sdmrc_axis u_axis_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .raw      (raw_y),
        .cfg      (cfg_y),
        .res      (res_y)
    );

    sdmrc_radial u_radial (
        .clk       (clk),
        .rst_n     (rst_n),
        .ax        (res_x),
        .ay        (res_y),
        .out_valid (done),
        .out_x     (out_x),
        .out_y     (out_y)
    );

    // both axis pipelines advance in lockstep
    a_axis_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        res_x.valid == res_y.valid)
        else $error("axis pipelines out of step");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without an accepted sample");

    a_accept_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LATENCY) done)
        else $error("accepted sample lost");

    // results always land inside the circle's bounding box
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_x <= 15'd32766 && out_y <= 15'd32766))
        else $error("result outside 0..2*mid");

endmodule
